// File: sv/kbm_pkg.sv
// ----------------------------------------------------------------------------
// kbm_pkg
// Shared types, codes and helpers of the knob and button mode controller.
// ----------------------------------------------------------------------------
package kbm_pkg;

	// Faces that carry a stored scale
	localparam int MAX_FACES = 16;

	// Time field limits
	localparam logic [5:0] HOUR_LIMIT   = 6'd24;
	localparam logic [5:0] MINSEC_LIMIT = 6'd60;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_POLLS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SET_TIME_MS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_IDLE_MS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_IDLE_MS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_STEP     = 3'd7;

	// Register reset values
	localparam logic [3:0]  RST_DEBOUNCE_POLLS = 4'd3;
	localparam logic [15:0] RST_LONG_PRESS_MS  = 16'd800;
	localparam logic [15:0] RST_SET_TIME_MS    = 16'd2500;
	localparam logic [15:0] RST_SCALE_IDLE_MS  = 16'd8000;
	localparam logic [15:0] RST_TIME_IDLE_MS   = 16'd30000;
	localparam logic [7:0]  RST_MIN_SCALE      = 8'd10;
	localparam logic [7:0]  RST_MAX_SCALE      = 8'd200;
	localparam logic [7:0]  RST_SCALE_STEP     = 8'd5;

	// Request codes
	localparam logic REQ_POLL = 1'b0;
	localparam logic REQ_SEED = 1'b1;

	// Button event codes
	localparam logic [1:0] BEV_NONE = 2'd0;
	localparam logic [1:0] BEV_TAP  = 2'd1;
	localparam logic [1:0] BEV_LONG = 2'd2;

	// Knob event codes
	localparam logic [1:0] KEV_NONE  = 2'd0;
	localparam logic [1:0] KEV_FACE  = 2'd1;
	localparam logic [1:0] KEV_TIME  = 2'd2;
	localparam logic [1:0] KEV_SCALE = 2'd3;

	// Time field codes
	localparam logic [1:0] FIELD_HOURS   = 2'd0;
	localparam logic [1:0] FIELD_MINUTES = 2'd1;
	localparam logic [1:0] FIELD_SECONDS = 2'd2;

	typedef struct packed {
		logic [3:0]  debounce_polls;
		logic [15:0] long_press_ms;
		logic [15:0] set_time_ms;
		logic [15:0] scale_idle_ms;
		logic [15:0] time_idle_ms;
		logic [7:0]  min_scale;
		logic [7:0]  max_scale;
		logic [7:0]  scale_step;
	} kbm_cfg_t;

	typedef struct packed {
		logic              req_type;
		logic              button_down;
		logic signed [7:0] detents;
		logic [31:0]       now_ms;
		logic [7:0]        face_id;
		logic [7:0]        current_scale;
		logic [4:0]        seed_hours;
		logic [5:0]        seed_minutes;
		logic [5:0]        seed_seconds;
	} kbm_item_t;

	typedef struct packed {
		logic [3:0]  press_count;
		logic        pressed;
		logic        long_reported;
		logic        set_reported;
		logic [31:0] press_start_ms;
		logic        scale_active;
		logic [31:0] scale_deadline;
		logic        time_active;
		logic [31:0] time_deadline;
		logic [1:0]  edit_field;
		logic        commit_flag;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
	} kbm_state_t;

	typedef struct packed {
		logic [1:0] button_event;
		logic [1:0] knob_event;
		logic       next_variant;
		logic       scale_mode;
		logic       time_mode;
		logic [1:0] time_field;
		logic       time_commit;
		logic       seed_request;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [7:0] scale_value;
	} kbm_result_t;

	// Wrap-safe deadline check: true once now has reached the deadline
	function automatic logic kbm_passed(logic [31:0] now, logic [31:0] deadline);
		logic [31:0] diff;
		diff = now - deadline;
		return ~diff[31];
	endfunction

	// (tv + det) mod lim, floored; lim is 24 or 60.
	// Offset by 6*lim keeps the sum positive and below 16*lim, so four
	// restoring steps finish the reduction.
	function automatic logic [5:0] kbm_wrap(logic [5:0] tv, logic signed [7:0] det,
		logic [5:0] lim);
		logic [10:0] w;
		logic [10:0] m;
		w = {5'b0, tv} + {{3{det[7]}}, det} + ({5'b0, lim} * 11'd6);
		for (int k = 3; k >= 0; k--) begin
			m = {5'b0, lim} << k;
			if (w >= m) begin
				w = w - m;
			end
		end
		return w[5:0];
	endfunction

endpackage

// File: sv/knob_button_mode_controller_top.sv
// ----------------------------------------------------------------------------
// knob_button_mode_controller_top
// Knob and button mode controller: one poll or seed transaction in, one
// result transaction out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one poll or seed request per
//    transaction. Output channel (out_valid/out_ready) returns exactly one
//    result per input, in order.
//  - Configuration: cfg_we with cfg_index/cfg_wdata writes one register per
//    cycle; write only while no transaction is in flight.
//  - Path: a taken input waits in the input register, then passes through the
//    poll logic into the result register.
//  - Throughput: one transaction per cycle while out_ready is high; the state is
//    updated as each transaction moves from the input to the result register.
//  - Stall: while out_ready is low the result holds, one more input can wait
//    in the input register, and in_ready drops once both are full.
//  - Reset: all mode and button state clears, registers return to defaults,
//    both channels come up empty.
// ----------------------------------------------------------------------------
module knob_button_mode_controller_top import kbm_pkg::*; #(
	parameter int FACE_LIMIT = MAX_FACES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic                  button_down,
	input  logic signed [7:0]     detents,
	input  logic [31:0]           now_ms,
	input  logic [7:0]            face_id,
	input  logic [7:0]            current_scale,
	input  logic [4:0]            seed_hours,
	input  logic [5:0]            seed_minutes,
	input  logic [5:0]            seed_seconds,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            button_event,
	output logic [1:0]            knob_event,
	output logic                  next_variant,
	output logic                  scale_mode,
	output logic                  time_mode,
	output logic [1:0]            time_field,
	output logic                  time_commit,
	output logic                  seed_request,
	output logic [4:0]            hours,
	output logic [5:0]            minutes,
	output logic [5:0]            seconds,
	output logic [7:0]            scale_value
);

	kbm_cfg_t    cfg_q;
	kbm_state_t  state_q;
	kbm_state_t  state_nxt;
	kbm_item_t   item_s1;
	logic        valid_s1;
	kbm_result_t res_nxt;
	kbm_result_t res_s2;
	logic        valid_s2;
	logic        advance;
	logic        in_fire;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_polls <= RST_DEBOUNCE_POLLS;
			cfg_q.long_press_ms  <= RST_LONG_PRESS_MS;
			cfg_q.set_time_ms    <= RST_SET_TIME_MS;
			cfg_q.scale_idle_ms  <= RST_SCALE_IDLE_MS;
			cfg_q.time_idle_ms   <= RST_TIME_IDLE_MS;
			cfg_q.min_scale      <= RST_MIN_SCALE;
			cfg_q.max_scale      <= RST_MAX_SCALE;
			cfg_q.scale_step     <= RST_SCALE_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_POLLS: cfg_q.debounce_polls <= cfg_wdata[3:0];
				REG_LONG_PRESS_MS:  cfg_q.long_press_ms  <= cfg_wdata;
				REG_SET_TIME_MS:    cfg_q.set_time_ms    <= cfg_wdata;
				REG_SCALE_IDLE_MS:  cfg_q.scale_idle_ms  <= cfg_wdata;
				REG_TIME_IDLE_MS:   cfg_q.time_idle_ms   <= cfg_wdata;
				REG_MIN_SCALE:      cfg_q.min_scale      <= cfg_wdata[7:0];
				REG_MAX_SCALE:      cfg_q.max_scale      <= cfg_wdata[7:0];
				REG_SCALE_STEP:     cfg_q.scale_step     <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.req_type      <= req_type;
			item_s1.button_down   <= button_down;
			item_s1.detents       <= detents;
			item_s1.now_ms        <= now_ms;
			item_s1.face_id       <= face_id;
			item_s1.current_scale <= current_scale;
			item_s1.seed_hours    <= seed_hours;
			item_s1.seed_minutes  <= seed_minutes;
			item_s1.seed_seconds  <= seed_seconds;
		end
	end

	// Poll logic
	kbm_step #(
		.FACE_LIMIT (FACE_LIMIT)
	) u_step (
		.cfg    (cfg_q),
		.item   (item_s1),
		.st     (state_q),
		.st_nxt (state_nxt),
		.res    (res_nxt)
	);

	// Controller state, updated as a transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign button_event = res_s2.button_event;
	assign knob_event   = res_s2.knob_event;
	assign next_variant = res_s2.next_variant;
	assign scale_mode   = res_s2.scale_mode;
	assign time_mode    = res_s2.time_mode;
	assign time_field   = res_s2.time_field;
	assign time_commit  = res_s2.time_commit;
	assign seed_request = res_s2.seed_request;
	assign hours        = res_s2.hours;
	assign minutes      = res_s2.minutes;
	assign seconds      = res_s2.seconds;
	assign scale_value  = res_s2.scale_value;

endmodule

// File: sv/kbm_step.sv
// ----------------------------------------------------------------------------
// kbm_step
// One poll or seed load of the controller: deadline expiry, detent handling and the
// button debounce / hold / tap logic, from the current state to the next state.
// ----------------------------------------------------------------------------
module kbm_step import kbm_pkg::*; #(
	parameter int FACE_LIMIT = MAX_FACES
) (
	input  kbm_cfg_t    cfg,
	input  kbm_item_t   item,
	input  kbm_state_t  st,
	output kbm_state_t  st_nxt,
	output kbm_result_t res
);

	always_comb begin
		kbm_state_t        n;
		logic [1:0]        bev;
		logic [1:0]        kev;
		logic [7:0]        scale_out;
		logic              variant;
		logic              seed;
		logic              skip_button;
		logic [1:0]        f;
		logic [31:0]       elapsed;
		logic signed [16:0] prod;
		logic signed [16:0] sv;

		n           = st;
		bev         = BEV_NONE;
		kev         = KEV_NONE;
		scale_out   = item.current_scale;
		variant     = 1'b0;
		seed        = 1'b0;
		skip_button = 1'b0;
		f           = (st.edit_field > FIELD_SECONDS) ? FIELD_SECONDS : st.edit_field;
		elapsed     = '0;

		// Scale arithmetic: current + detents * step, clamped floor then ceiling
		prod = item.detents * $signed({1'b0, cfg.scale_step});
		sv   = prod + $signed({9'b0, item.current_scale});
		if (sv < $signed({9'b0, cfg.min_scale})) begin
			sv = $signed({9'b0, cfg.min_scale});
		end
		if (sv > $signed({9'b0, cfg.max_scale})) begin
			sv = $signed({9'b0, cfg.max_scale});
		end

		if (item.req_type == REQ_SEED) begin
			// Seed load: time values only
			n.hours   = item.seed_hours;
			n.minutes = item.seed_minutes;
			n.seconds = item.seed_seconds;
		end else begin
			// Mode expiry
			if (n.scale_active && kbm_passed(item.now_ms, n.scale_deadline)) begin
				n.scale_active = 1'b0;
			end
			if (n.time_active && kbm_passed(item.now_ms, n.time_deadline)) begin
				n.time_active = 1'b0;
			end

			// Detents
			if (item.detents != 8'sd0 && n.time_active) begin
				case (f)
					FIELD_HOURS: begin
						n.hours = 5'(kbm_wrap({1'b0, n.hours}, item.detents, HOUR_LIMIT));
					end
					FIELD_MINUTES: begin
						n.minutes = kbm_wrap(n.minutes, item.detents, MINSEC_LIMIT);
					end
					default: begin
						n.seconds = kbm_wrap(n.seconds, item.detents, MINSEC_LIMIT);
					end
				endcase
				n.time_deadline = item.now_ms + {16'b0, cfg.time_idle_ms};
				kev = KEV_TIME;
			end else if (item.detents != 8'sd0 && n.scale_active) begin
				if ({1'b0, item.face_id} >= 9'(FACE_LIMIT)) begin
					skip_button = 1'b1;
				end else begin
					scale_out        = sv[7:0];
					n.scale_deadline = item.now_ms + {16'b0, cfg.scale_idle_ms};
					kev = KEV_SCALE;
				end
			end else if (item.detents != 8'sd0) begin
				kev = KEV_FACE;
			end

			// Button
			if (!skip_button) begin
				if (item.button_down) begin
					if (n.press_count < cfg.debounce_polls) begin
						n.press_count = n.press_count + 4'd1;
					end
					if (n.press_count == cfg.debounce_polls && !n.pressed) begin
						n.pressed        = 1'b1;
						n.long_reported  = 1'b0;
						n.press_start_ms = item.now_ms;
					end
					elapsed = item.now_ms - n.press_start_ms;
					// long press toggles scale mode
					if (n.pressed && !n.long_reported &&
						elapsed >= {16'b0, cfg.long_press_ms}) begin
						n.long_reported  = 1'b1;
						n.scale_active   = ~n.scale_active;
						n.scale_deadline = item.now_ms + {16'b0, cfg.scale_idle_ms};
						bev = BEV_LONG;
					end
					// longer hold enters time edit
					if (n.pressed && n.long_reported && !n.set_reported &&
						elapsed >= {16'b0, cfg.set_time_ms}) begin
						n.set_reported  = 1'b1;
						n.scale_active  = 1'b0;
						n.time_active   = 1'b1;
						n.edit_field    = FIELD_HOURS;
						n.commit_flag   = 1'b0;
						n.time_deadline = item.now_ms + {16'b0, cfg.time_idle_ms};
						seed = 1'b1;
					end
				end else begin
					// tap on release
					if (n.pressed && !n.long_reported) begin
						if (n.time_active) begin
							if (n.edit_field < FIELD_SECONDS) begin
								n.edit_field    = n.edit_field + 2'd1;
								n.time_deadline = item.now_ms + {16'b0, cfg.time_idle_ms};
							end else begin
								n.commit_flag = 1'b1;
								n.time_active = 1'b0;
							end
						end else if (n.scale_active) begin
							n.scale_active = 1'b0;
						end else begin
							variant = 1'b1;
						end
						bev = BEV_TAP;
					end
					n.press_count  = '0;
					n.pressed      = 1'b0;
					n.set_reported = 1'b0;
				end
			end
		end

		st_nxt = n;

		res.button_event = bev;
		res.knob_event   = kev;
		res.next_variant = variant;
		res.scale_mode   = n.scale_active;
		res.time_mode    = n.time_active;
		res.time_field   = n.edit_field;
		res.time_commit  = n.commit_flag;
		res.seed_request = seed;
		res.hours        = n.hours;
		res.minutes      = n.minutes;
		res.seconds      = n.seconds;
		res.scale_value  = scale_out;
	end

endmodule

// File: sv/kbm_checker.sv
// ----------------------------------------------------------------------------
// kbm_checker
// Port-level checks of the knob and button mode controller, bound to the top.
// ----------------------------------------------------------------------------
module kbm_checker import kbm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] button_event,
	input logic [1:0] knob_event,
	input logic       next_variant,
	input logic       scale_mode,
	input logic       time_mode,
	input logic [1:0] time_field,
	input logic       time_commit,
	input logic       seed_request,
	input logic [7:0] scale_value
);

	// A stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(button_event) &&
		$stable(knob_event) && $stable(scale_value) && $stable(time_field))
		else $error("result changed while stalled");

	// Entering time edit starts at hours, uncommitted, with scale mode off
	a_seed_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seed_request |-> time_mode && !scale_mode && !time_commit &&
		time_field == FIELD_HOURS && button_event != BEV_TAP)
		else $error("bad state on time edit entry");

	// A variant request only comes from a tap with no mode active
	a_variant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && next_variant |-> button_event == BEV_TAP && !scale_mode &&
		!time_mode && !seed_request)
		else $error("variant request outside idle tap");

endmodule

bind knob_button_mode_controller_top kbm_checker u_kbm_checker (.*);

// File: sim/knob_button_mode_controller_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_button_mode_controller_top_test
// Self-checking bench for the knob and button mode controller. A short table
// of polls and seed loads walks taps, long and very long holds, scale and time
// edit modes and the scale mode timeout. Random gestures then follow under several
// register settings and handshake stall patterns. Every result transaction is
// checked field by field against an in-bench model, or the table for typed rows.
// ----------------------------------------------------------------------------
module knob_button_mode_controller_top_test import kbm_pkg::*;;

	localparam int QUIET_LIMIT       = 5000;
	localparam int ITEMS_PER_SEGMENT = 188;
	localparam int SEGMENTS          = 6;

	// One row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic        typed;
		kbm_item_t   stim;
		kbm_result_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 25;

	// Directed table, run with zero debounce and the remaining registers at reset
	localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
		// after reset: nothing active, scale passes through
		'{1'b1, '{REQ_POLL, 1'b0, 8'sd0, 32'd0, 8'd0, 8'd0, 5'd0, 6'd0, 6'd0},
			'{BEV_NONE, KEV_NONE, 1'b0, 1'b0, 1'b0, FIELD_HOURS, 1'b0, 1'b0,
			5'd0, 6'd0, 6'd0, 8'd0}},
		// detent extremes with no mode: face move
		'{1'b1, '{REQ_POLL, 1'b0, 8'sd127, 32'd10, 8'd255, 8'd255, 5'd0, 6'd0, 6'd0},
			'{BEV_NONE, KEV_FACE, 1'b0, 1'b0, 1'b0, FIELD_HOURS, 1'b0, 1'b0,
			5'd0, 6'd0, 6'd0, 8'd255}},
		'{1'b1, '{REQ_POLL, 1'b0, 8'sh80, 32'd20, 8'd0, 8'd128, 5'd0, 6'd0, 6'd0},
			'{BEV_NONE, KEV_FACE, 1'b0, 1'b0, 1'b0, FIELD_HOURS, 1'b0, 1'b0,
			5'd0, 6'd0, 6'd0, 8'd128}},
		// seed load of out-of-range values, button level ignored
		'{1'b1, '{REQ_SEED, 1'b1, 8'sd0, 32'd30, 8'd0, 8'd77, 5'd31, 6'd63, 6'd63},
			'{BEV_NONE, KEV_NONE, 1'b0, 1'b0, 1'b0, FIELD_HOURS, 1'b0, 1'b0,
			5'd31, 6'd63, 6'd63, 8'd77}},
		// press taken on the first poll, long press, then time edit entry
		'{1'b0, '{REQ_POLL, 1'b1, 8'sd0, 32'd100, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b1, 8'sd0, 32'd900, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b1, 8'sd0, 32'd2600, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, 8'sd0, 32'd2610, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		// out-of-range hours wrapped by a full negative turn
		'{1'b0, '{REQ_POLL, 1'b0, 8'sh80, 32'd2620, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b1, 8'sd0, 32'd2700, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, 8'sd0, 32'd2710, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, 8'sd127, 32'd2720, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b1, 8'sd0, 32'd2800, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, 8'sd0, 32'd2810, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, -8'sd1, 32'd2820, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		// last tap commits the edited time
		'{1'b0, '{REQ_POLL, 1'b1, 8'sd0, 32'd2900, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, 8'sd0, 32'd2910, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		// scale mode: face out of range skips the button handling, then clamp at both ends
		'{1'b0, '{REQ_POLL, 1'b1, 8'sd0, 32'd5000, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b1, 8'sd0, 32'd5800, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, 8'sd1, 32'd5810, 8'd20, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, 8'sd127, 32'd5820, 8'd3, 8'd100, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, 8'sh80, 32'd5830, 8'd15, 8'd100, 5'd0, 6'd0, 6'd0}, '0},
		// scale mode times out, then a plain tap asks for the next variant
		'{1'b0, '{REQ_POLL, 1'b0, 8'sd0, 32'd30000, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b1, 8'sd0, 32'd30010, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0},
		'{1'b0, '{REQ_POLL, 1'b0, 8'sd0, 32'd30020, 8'd0, 8'd50, 5'd0, 6'd0, 6'd0}, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	kbm_item_t             drv_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            button_event;
	logic [1:0]            knob_event;
	logic                  next_variant;
	logic                  scale_mode;
	logic                  time_mode;
	logic [1:0]            time_field;
	logic                  time_commit;
	logic                  seed_request;
	logic [4:0]            hours;
	logic [5:0]            minutes;
	logic [5:0]            seconds;
	logic [7:0]            scale_value;
	kbm_result_t           dut_result;

	// Model of the controller: registers and state
	kbm_cfg_t    cur_cfg = '{RST_DEBOUNCE_POLLS, RST_LONG_PRESS_MS, RST_SET_TIME_MS,
		RST_SCALE_IDLE_MS, RST_TIME_IDLE_MS, RST_MIN_SCALE, RST_MAX_SCALE, RST_SCALE_STEP};
	logic [3:0]  press_polls = '0;
	logic        held = 1'b0;
	logic        long_done = 1'b0;
	logic        set_done = 1'b0;
	logic [31:0] press_t0 = '0;
	logic        scale_on = 1'b0;
	logic [31:0] scale_due = '0;
	logic        edit_on = 1'b0;
	logic [31:0] edit_due = '0;
	logic [1:0]  edit_sel = FIELD_HOURS;
	logic        commit_on = 1'b0;
	logic [5:0]  tval [3] = '{6'd0, 6'd0, 6'd0};

	kbm_result_t pending_results [$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	logic [31:0] wall = '0;
	logic [31:0] tick = 32'd1;

	knob_button_mode_controller_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (drv_item.req_type),
		.button_down   (drv_item.button_down),
		.detents       (drv_item.detents),
		.now_ms        (drv_item.now_ms),
		.face_id       (drv_item.face_id),
		.current_scale (drv_item.current_scale),
		.seed_hours    (drv_item.seed_hours),
		.seed_minutes  (drv_item.seed_minutes),
		.seed_seconds  (drv_item.seed_seconds),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.button_event  (button_event),
		.knob_event    (knob_event),
		.next_variant  (next_variant),
		.scale_mode    (scale_mode),
		.time_mode     (time_mode),
		.time_field    (time_field),
		.time_commit   (time_commit),
		.seed_request  (seed_request),
		.hours         (hours),
		.minutes       (minutes),
		.seconds       (seconds),
		.scale_value   (scale_value)
	);

	assign dut_result = {button_event, knob_event, next_variant, scale_mode, time_mode,
		time_field, time_commit, seed_request, hours, minutes, seconds, scale_value};

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Deadline test that survives the millisecond counter wrapping
	function automatic logic reached(input logic [31:0] now, input logic [31:0] mark);
		logic [31:0] gap;
		gap = now - mark;
		return gap < 32'h8000_0000;
	endfunction

	// Advance the model by one transaction and return the result it produces
	function automatic kbm_result_t step_controller(input kbm_item_t it);
		kbm_result_t r;
		logic [1:0]  sel;
		logic        skip;
		logic        turned;
		logic [31:0] held_ms;
		int          lim;
		int          v;
		r = '0;
		r.scale_value = it.current_scale;
		skip = 1'b0;
		turned = (it.detents != 8'sd0);
		if (it.req_type == REQ_SEED) begin
			tval[0] = {1'b0, it.seed_hours};
			tval[1] = it.seed_minutes;
			tval[2] = it.seed_seconds;
		end else begin
			sel = (edit_sel > FIELD_SECONDS) ? FIELD_SECONDS : edit_sel;
			// mode timeouts first
			if (scale_on && reached(it.now_ms, scale_due)) scale_on = 1'b0;
			if (edit_on && reached(it.now_ms, edit_due)) edit_on = 1'b0;

			// knob: time field, then scale, else face move
			if (turned && edit_on) begin
				lim = (sel == FIELD_HOURS) ? int'(HOUR_LIMIT) : int'(MINSEC_LIMIT);
				v = int'(tval[sel]) + int'($signed(it.detents));
				v = v % lim;
				if (v < 0) v = v + lim;
				tval[sel] = v[5:0];
				edit_due = it.now_ms + {16'd0, cur_cfg.time_idle_ms};
				r.knob_event = KEV_TIME;
			end else if (turned && scale_on) begin
				if (it.face_id >= MAX_FACES) begin
					skip = 1'b1;
				end else begin
					v = int'(it.current_scale) +
						int'($signed(it.detents)) * int'(cur_cfg.scale_step);
					if (v < int'(cur_cfg.min_scale)) v = int'(cur_cfg.min_scale);
					if (v > int'(cur_cfg.max_scale)) v = int'(cur_cfg.max_scale);
					r.scale_value = v[7:0];
					scale_due = it.now_ms + {16'd0, cur_cfg.scale_idle_ms};
					r.knob_event = KEV_SCALE;
				end
			end else if (turned) begin
				r.knob_event = KEV_FACE;
			end

			// button: debounce, long hold, set hold, tap on release
			if (!skip) begin
				if (it.button_down) begin
					if (press_polls < cur_cfg.debounce_polls) press_polls = press_polls + 4'd1;
					if (press_polls == cur_cfg.debounce_polls && !held) begin
						held = 1'b1;
						long_done = 1'b0;
						press_t0 = it.now_ms;
					end
					held_ms = it.now_ms - press_t0;
					if (held && !long_done && held_ms >= {16'd0, cur_cfg.long_press_ms}) begin
						long_done = 1'b1;
						scale_on = !scale_on;
						scale_due = it.now_ms + {16'd0, cur_cfg.scale_idle_ms};
						r.button_event = BEV_LONG;
					end
					if (held && long_done && !set_done &&
						held_ms >= {16'd0, cur_cfg.set_time_ms}) begin
						set_done = 1'b1;
						scale_on = 1'b0;
						edit_on = 1'b1;
						edit_sel = FIELD_HOURS;
						r.seed_request = 1'b1;
						commit_on = 1'b0;
						edit_due = it.now_ms + {16'd0, cur_cfg.time_idle_ms};
					end
				end else begin
					if (held && !long_done) begin
						if (edit_on) begin
							if (edit_sel < FIELD_SECONDS) begin
								edit_sel = edit_sel + 2'd1;
								edit_due = it.now_ms + {16'd0, cur_cfg.time_idle_ms};
							end else begin
								commit_on = 1'b1;
								edit_on = 1'b0;
							end
						end else if (scale_on) begin
							scale_on = 1'b0;
						end else begin
							r.next_variant = 1'b1;
						end
						r.button_event = BEV_TAP;
					end
					press_polls = '0;
					held = 1'b0;
					set_done = 1'b0;
				end
			end
		end
		r.scale_mode = scale_on;
		r.time_mode = edit_on;
		r.time_field = edit_sel;
		r.time_commit = commit_on;
		r.hours = tval[0][4:0];
		r.minutes = tval[1];
		r.seconds = tval[2];
		return r;
	endfunction

	function automatic void compare_field(input string name, input int want, input int seen);
		if (want != seen) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
			mismatches++;
		end
	endfunction

	// Drive one input transaction; the model runs when it is accepted
	task automatic send_item(input kbm_item_t it, input logic typed, input kbm_result_t want);
		kbm_result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		drv_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = step_controller(it);
		pending_results.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// Poll with the wall clock moved on by dt; turn forces a knob movement
	task automatic poll(input logic down, input logic turn, input logic [31:0] dt);
		kbm_item_t it;
		logic signed [7:0] d;
		if (turn) begin
			if ($urandom_range(0, 7) == 0) begin
				d = 8'($urandom);
			end else begin
				d = 8'($urandom_range(1, 4));
				if ($urandom_range(0, 1) == 1) d = -d;
			end
		end else begin
			d = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'sd0;
		end
		wall = wall + dt;
		it.req_type = REQ_POLL;
		it.button_down = down;
		it.detents = d;
		it.now_ms = wall;
		it.face_id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(MAX_FACES, 255)) :
			8'($urandom_range(0, MAX_FACES - 1));
		it.current_scale = 8'($urandom);
		it.seed_hours = 5'($urandom);
		it.seed_minutes = 6'($urandom);
		it.seed_seconds = 6'($urandom);
		send_item(it, 1'b0, '0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
	endtask

	// Write the whole register set; only called with nothing in flight
	task automatic load_settings(input kbm_cfg_t c);
		write_reg(REG_DEBOUNCE_POLLS, {12'd0, c.debounce_polls});
		write_reg(REG_LONG_PRESS_MS, c.long_press_ms);
		write_reg(REG_SET_TIME_MS, c.set_time_ms);
		write_reg(REG_SCALE_IDLE_MS, c.scale_idle_ms);
		write_reg(REG_TIME_IDLE_MS, c.time_idle_ms);
		write_reg(REG_MIN_SCALE, {8'd0, c.min_scale});
		write_reg(REG_MAX_SCALE, {8'd0, c.max_scale});
		write_reg(REG_SCALE_STEP, {8'd0, c.scale_step});
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	// Stop sending and wait until every expected result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Result checking against the oldest expectation
	always @(posedge clk) begin : check_results
		kbm_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result transaction with no expectation pending", $time);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("button_event", want.button_event, dut_result.button_event);
				compare_field("knob_event", want.knob_event, dut_result.knob_event);
				compare_field("next_variant", want.next_variant, dut_result.next_variant);
				compare_field("scale_mode", want.scale_mode, dut_result.scale_mode);
				compare_field("time_mode", want.time_mode, dut_result.time_mode);
				compare_field("time_field", want.time_field, dut_result.time_field);
				compare_field("time_commit", want.time_commit, dut_result.time_commit);
				compare_field("seed_request", want.seed_request, dut_result.seed_request);
				compare_field("hours", want.hours, dut_result.hours);
				compare_field("minutes", want.minutes, dut_result.minutes);
				compare_field("seconds", want.seconds, dut_result.seconds);
				compare_field("scale_value", want.scale_value, dut_result.scale_value);
			end
		end
	end

	// Watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Stimulus
	initial begin
		kbm_cfg_t    c;
		kbm_item_t   it;
		logic [95:0] bits;
		logic [31:0] longest;
		int          goal;
		int          n;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table with zero debounce
		send_gap_pct = 9;
		recv_stall_pct = 57;
		c = cur_cfg;
		c.debounce_polls = 4'd0;
		load_settings(c);
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_item(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end
		wall = 32'd40000;

		// random gestures, one register setting per segment
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			case (seg)
				0: c = '{RST_DEBOUNCE_POLLS, RST_LONG_PRESS_MS, RST_SET_TIME_MS,
					RST_SCALE_IDLE_MS, RST_TIME_IDLE_MS, RST_MIN_SCALE, RST_MAX_SCALE,
					RST_SCALE_STEP};
				1: c = '{4'd1, 16'd100, 16'd250, 16'd600, 16'd900, 8'd0, 8'd255, 8'd1};
				// inverted clamp, zero hold and idle times, deepest debounce
				2: c = '{4'd15, 16'd0, 16'd0, 16'd0, 16'd0, 8'd255, 8'd0, 8'd255};
				3: c = '{4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd100, 8'd100, 8'd0};
				default: begin
					c.debounce_polls = 4'($urandom_range(1, 4));
					c.long_press_ms = 16'($urandom_range(20, 400));
					c.set_time_ms = c.long_press_ms + 16'($urandom_range(0, 400));
					c.scale_idle_ms = 16'($urandom_range(100, 3000));
					c.time_idle_ms = 16'($urandom_range(100, 3000));
					c.min_scale = 8'($urandom_range(0, 120));
					c.max_scale = 8'($urandom_range(100, 255));
					c.scale_step = 8'($urandom_range(1, 20));
				end
			endcase
			load_settings(c);
			send_gap_pct = (seg < 2) ? 9 : (seg < 4) ? 57 : 0;
			recv_stall_pct = (seg < 2) ? 57 : (seg < 4) ? 9 : 0;
			// run the millisecond counter through its wrap
			if (seg == 1) wall = 32'hFFFF_FF00;
			tick = ((c.set_time_ms > c.long_press_ms) ? {16'd0, c.set_time_ms} :
				{16'd0, c.long_press_ms}) / 5 + 32'd1;
			longest = ((c.scale_idle_ms > c.time_idle_ms) ? {16'd0, c.scale_idle_ms} :
				{16'd0, c.time_idle_ms}) * 2 + 32'd1;
			goal = items_sent + ITEMS_PER_SEGMENT;
			while (items_sent < goal) begin
				case ($urandom_range(0, 9))
					// tap
					0, 1: begin
						n = ((c.debounce_polls == 4'd0) ? 1 : int'(c.debounce_polls)) +
							int'($urandom_range(0, 1));
						repeat (n) poll(1'b1, 1'b0, $urandom_range(0, tick / 4));
						poll(1'b0, 1'b0, $urandom_range(0, tick / 4));
					end
					// long or very long hold, knob sometimes turned meanwhile
					2, 3: begin
						n = int'(c.debounce_polls) + int'($urandom_range(1, 12));
						repeat (n) poll(1'b1, $urandom_range(0, 3) == 0, $urandom_range(0, tick));
						poll(1'b0, 1'b0, $urandom_range(0, tick / 4));
					end
					// knob turns
					4, 5: begin
						repeat ($urandom_range(1, 4)) poll(1'b0, 1'b1, $urandom_range(0, tick / 4));
					end
					// seed load, values not always in range
					6: begin
						it.req_type = REQ_SEED;
						it.button_down = 1'($urandom);
						it.detents = 8'($urandom);
						it.now_ms = wall;
						it.face_id = 8'($urandom);
						it.current_scale = 8'($urandom);
						it.seed_hours = 5'($urandom);
						it.seed_minutes = 6'($urandom);
						it.seed_seconds = 6'($urandom);
						send_item(it, 1'b0, '0);
					end
					// quiet stretch of up to twice the longer idle time, so the modes can time out
					7: poll(1'b0, 1'b0, $urandom_range(0, longest));
					// noise: every field random, time included
					8: begin
						bits = {$urandom, $urandom, $urandom};
						it = bits[$bits(kbm_item_t)-1:0];
						send_item(it, 1'b0, '0);
					end
					default: begin
						repeat (3) poll(1'($urandom), 1'($urandom), $urandom_range(0, tick));
					end
				endcase
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: files.f
sv/kbm_pkg.sv
sv/kbm_step.sv
sv/knob_button_mode_controller_top.sv
sv/kbm_checker.sv
sim/knob_button_mode_controller_top_test.sv
